>>> rtl/irn_pkg.sv
package irn_pkg;

  // fixed field widths
  localparam int POS_W      = 8;
  localparam int PIX_W      = 24;
  localparam int DIM_W      = 9;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // defaults for the top level parameters
  localparam int DEF_MAX_WIDTH      = 256;
  localparam int DEF_MAX_HEIGHT     = 256;
  localparam int DEF_COEF_FRAC_BITS = 14;

  // frame size after reset
  localparam int DIM_RESET = 256;

  // beat opcode
  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 8'd0,
    REG_HEIGHT = 8'd1,
    REG_COS    = 8'd2,
    REG_SIN    = 8'd3
  } cfg_reg_t;

  // live configuration, dimensions already clamped
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [COEF_W-1:0] cos_v;
    logic [COEF_W-1:0] sin_v;
  } cfg_t;

  // memory access issued by the mapping pipeline
  typedef struct packed {
    logic valid;
    logic write;
    logic read;
    logic fetch;
    logic in_frame;
  } req_t;

  // zero counts as one, anything above the frame limit saturates
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

endpackage

>>> rtl/irn_if.sv
// pixel beat into the block
interface irn_in_if import irn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, cmd, pos_x, pos_y, pixel_in, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pixel_in, output ready);
endinterface

// rotated pixel out of the block
interface irn_out_if import irn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             src_inside;

  modport source (output valid, out_pixel, src_inside, input ready);
  modport sink (input valid, out_pixel, src_inside, output ready);
endinterface

// register write channel
interface irn_cfg_if import irn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/image_rotate_nearest.sv
// Nearest-neighbor image rotation about the frame center.
// in_bus carries beats of cmd, pos_x, pos_y, pixel_in. A store beat writes
// pixel_in into the frame store at (pos_x, pos_y) when that lies inside the
// configured frame and gives no result. A fetch beat names a destination
// pixel; the block rotates it back into the source frame with the cos/sin
// registers and returns one out_bus beat: the stored pixel and src_inside
// high, or zero and src_inside low when the source falls outside the frame.
// cfg_bus writes frame_width, frame_height, cos_value, sin_value by index;
// it is always ready, and the user writes it only while the block is idle.
// The block does not enforce this. out_bus valid follows an accepted fetch
// beat through four registers: input, multiplier, address, memory read.
// Throughput is one beat per cycle while out_bus does not stall, set by the
// single frame store port, which takes one store or one fetch each cycle.
// Reset clears the pipeline, loads 256x256 (clamped), cos one, sin zero;
// the store is not cleared: the user loads every pixel before fetching.
// When out_bus stalls the result holds and the whole pipeline freezes;
// in_bus.ready follows an empty or draining result register.
module image_rotate_nearest import irn_pkg::*; #(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  irn_in_if.sink     in_bus,
  irn_out_if.source  out_bus,
  irn_cfg_if.sink    cfg_bus
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RH = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RH;

  cfg_t             cfg;
  req_t             req;
  logic [AW-1:0]    req_addr;
  logic [PIX_W-1:0] req_pix;
  logic [PIX_W-1:0] rd_data;
  logic             advance;
  logic             ram_we;
  logic             ram_re;
  logic             out_valid_r;
  logic             out_inside_r;

  // pipeline moves whenever the result register is free or draining
  assign advance      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = advance;

  irn_cfg #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  irn_map #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (in_bus.valid),
    .in_cmd   (in_bus.cmd),
    .in_px    (in_bus.pos_x),
    .in_py    (in_bus.pos_y),
    .in_pix   (in_bus.pixel_in),
    .cfg      (cfg),
    .req      (req),
    .req_addr (req_addr),
    .req_pix  (req_pix)
  );

  // frame store access
  assign ram_we = advance && req.valid && req.write;
  assign ram_re = advance && req.valid && req.read;

  irn_ram #(
    .WIDTH (PIX_W),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (req_addr),
    .wdata (req_pix),
    .rdata (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= req.valid && req.fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_inside_r <= req.in_frame;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.src_inside = out_inside_r;
  assign out_bus.out_pixel  = out_inside_r ? rd_data : '0;

  // a source outside the frame always reads as black
  a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.src_inside) |-> (out_bus.out_pixel == '0))
    else $error("outside source returned a nonzero pixel");

  // one beat owns the memory port at a time
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store and fetch on the frame store in one cycle");

  // an empty result register never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_bus.ready)
    else $error("input stalled with empty result register");

  // a stalled result keeps its memory data
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> $stable(rd_data))
    else $error("read data changed under a stalled result");

endmodule

>>> rtl/irn_ram.sv
module irn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/irn_cfg.sv
module irn_cfg import irn_pkg::*; #(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  irn_cfg_if.sink   cfg_bus,
  output cfg_t      cfg
);

  // unit cosine, saturated to the signed coefficient range
  localparam int COS_ONE_I = (COEF_FRAC_BITS >= COEF_W - 1) ?
                             ((1 << (COEF_W - 1)) - 1) : (1 << COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] COS_RESET = COEF_W'(COS_ONE_I);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  // decode a register write, clamp dimensions on the way in
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_WIDTH:  cfg_nxt.width  = eff_dim(cfg_bus.data[DIM_W-1:0], MAX_WIDTH);
        REG_HEIGHT: cfg_nxt.height = eff_dim(cfg_bus.data[DIM_W-1:0], MAX_HEIGHT);
        REG_COS:    cfg_nxt.cos_v  = cfg_bus.data[COEF_W-1:0];
        REG_SIN:    cfg_nxt.sin_v  = cfg_bus.data[COEF_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= eff_dim(DIM_W'(DIM_RESET), MAX_WIDTH);
      cfg_r.height <= eff_dim(DIM_W'(DIM_RESET), MAX_HEIGHT);
      cfg_r.cos_v  <= COS_RESET;
      cfg_r.sin_v  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/irn_map.sv
module irn_map import irn_pkg::*; #(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  localparam int CW            = $clog2(MAX_WIDTH),
  localparam int RH            = $clog2(MAX_HEIGHT),
  localparam int AW            = CW + RH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic             in_cmd,
  input  logic [POS_W-1:0] in_px,
  input  logic [POS_W-1:0] in_py,
  input  logic [PIX_W-1:0] in_pix,
  input  cfg_t             cfg,
  output req_t             req,
  output logic [AW-1:0]    req_addr,
  output logic [PIX_W-1:0] req_pix
);

  // half-pixel offset, product and sum widths
  localparam int DX_W  = POS_W + 3;
  localparam int PR_W  = DX_W + COEF_W;
  localparam int BASE  = (PR_W + 1 > DIM_W + 1 + COEF_FRAC_BITS) ?
                         (PR_W + 1) : (DIM_W + 1 + COEF_FRAC_BITS);
  localparam int SUM_W = BASE + 2;
  localparam int QW    = SUM_W - COEF_FRAC_BITS - 1;

  // input register
  logic             a_valid_r;
  logic             a_cmd_r;
  logic [POS_W-1:0] a_px_r;
  logic [POS_W-1:0] a_py_r;
  logic [PIX_W-1:0] a_pix_r;

  // product register
  logic                   b_valid_r;
  logic                   b_cmd_r;
  logic                   b_store_ok_r;
  logic [POS_W-1:0]       b_px_r;
  logic [POS_W-1:0]       b_py_r;
  logic [PIX_W-1:0]       b_pix_r;
  logic signed [PR_W-1:0] b_xc_r;
  logic signed [PR_W-1:0] b_ys_r;
  logic signed [PR_W-1:0] b_xs_r;
  logic signed [PR_W-1:0] b_yc_r;

  // access register
  req_t             c_req_r;
  req_t             c_req_nxt;
  logic [AW-1:0]    c_addr_r;
  logic [AW-1:0]    c_addr_nxt;
  logic [PIX_W-1:0] c_pix_r;

  logic signed [DX_W-1:0]  dx;
  logic signed [DX_W-1:0]  dy;
  logic signed [SUM_W-1:0] w_sh;
  logic signed [SUM_W-1:0] h_sh;
  logic signed [SUM_W-1:0] sx;
  logic signed [SUM_W-1:0] sy;
  logic [QW-1:0]           qx;
  logic [QW-1:0]           qy;
  logic                    in_x;
  logic                    in_y;

  // offsets from the centre in half pixels
  assign dx = $signed({2'b00, a_px_r, 1'b0}) - $signed(DX_W'(cfg.width));
  assign dy = $signed({2'b00, a_py_r, 1'b0}) - $signed(DX_W'(cfg.height));

  // centre back in, then floor and range check
  assign w_sh = SUM_W'(cfg.width) << COEF_FRAC_BITS;
  assign h_sh = SUM_W'(cfg.height) << COEF_FRAC_BITS;
  assign sx   = SUM_W'(b_xc_r) - SUM_W'(b_ys_r) + w_sh;
  assign sy   = SUM_W'(b_xs_r) + SUM_W'(b_yc_r) + h_sh;
  assign qx   = sx[SUM_W-1:COEF_FRAC_BITS+1];
  assign qy   = sy[SUM_W-1:COEF_FRAC_BITS+1];
  assign in_x = !sx[SUM_W-1] && (qx < QW'(cfg.width));
  assign in_y = !sy[SUM_W-1] && (qy < QW'(cfg.height));

  // access decode for the memory stage
  always_comb begin
    c_req_nxt.valid    = b_valid_r;
    c_req_nxt.fetch    = (b_cmd_r == CMD_FETCH);
    c_req_nxt.in_frame = in_x && in_y;
    c_req_nxt.write    = (b_cmd_r == CMD_STORE) && b_store_ok_r;
    c_req_nxt.read     = (b_cmd_r == CMD_FETCH) && in_x && in_y;
    if (b_cmd_r == CMD_FETCH) begin
      c_addr_nxt = {RH'(qy), CW'(qx)};
    end else begin
      c_addr_nxt = {RH'(b_py_r), CW'(b_px_r)};
    end
  end

  // pipeline valids and the access request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      b_valid_r     <= 1'b0;
      c_req_r.valid <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_req_r   <= c_req_nxt;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd_r      <= in_cmd;
      a_px_r       <= in_px;
      a_py_r       <= in_py;
      a_pix_r      <= in_pix;
      b_cmd_r      <= a_cmd_r;
      b_px_r       <= a_px_r;
      b_py_r       <= a_py_r;
      b_pix_r      <= a_pix_r;
      b_store_ok_r <= (DIM_W'(a_px_r) < cfg.width) && (DIM_W'(a_py_r) < cfg.height);
      b_xc_r       <= dx * $signed(cfg.cos_v);
      b_ys_r       <= dy * $signed(cfg.sin_v);
      b_xs_r       <= dx * $signed(cfg.sin_v);
      b_yc_r       <= dy * $signed(cfg.cos_v);
      c_addr_r     <= c_addr_nxt;
      c_pix_r      <= b_pix_r;
    end
  end

  assign req      = c_req_r;
  assign req_addr = c_addr_r;
  assign req_pix  = c_pix_r;

endmodule
